FILE: hw/rtl/nevc_pkg.sv
// Shared types, constants and tables for the view cone nearest entity finder.
// Used by the channel interfaces, the controller, the datapath and the top level.
package nevc_pkg;

   localparam int ANGLE_BITS      = 16;
   localparam int POS_FRAC_BITS   = 6;
   localparam int ITEM_NAME_COUNT = 37;

   localparam int POS_W    = 24;
   localparam int HEIGHT_W = 8;
   localparam int ANGLE_W  = 16;
   localparam int KIND_W   = 2;
   localparam int MODEL_W  = 8;
   localparam int HIT_W    = 2;
   localparam int INDEX_W  = 6;
   localparam int PHASE_W  = 24;
   localparam int DIFF_W   = POS_W + 1;
   localparam int DIR_W    = 17;
   localparam int DIST_W   = 23;
   localparam int COS_W    = 16;
   localparam int MUL_W    = 33;
   localparam int PROD_W   = 64;
   localparam int ACC_W    = 52;
   localparam int SQ_W     = 50;
   localparam int ROOT_W   = 25;
   localparam int T_W      = 31;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 23;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DIST = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_CONE = 1'd1;

   localparam logic [DIST_W-1:0]       MAX_DIST_RESET = 23'd65536;
   localparam logic signed [COS_W-1:0] COS_CONE_RESET = 16'sd32113;

   localparam logic CMD_VIEW   = 1'b0;
   localparam logic CMD_ENTITY = 1'b1;

   localparam logic [KIND_W-1:0] ENT_PICKUP = 2'd1;
   localparam logic [KIND_W-1:0] ENT_PLAYER = 2'd2;

   localparam logic [HIT_W-1:0] HIT_NONE    = 2'd0;
   localparam logic [HIT_W-1:0] HIT_PLAYER  = 2'd1;
   localparam logic [HIT_W-1:0] HIT_NAMED   = 2'd2;
   localparam logic [HIT_W-1:0] HIT_GENERIC = 2'd3;

   localparam logic [31:0] SINE_C_FIRST = 32'd172272;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_LOAD,
      OP_SIN,
      OP_DIR,
      OP_SQ,
      OP_SQRT,
      OP_DOT,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] step;
      logic [1:0] angle;
   } cmd_type;

   typedef struct packed {
      logic is_view;
      logic needs_work;
      logic last;
      logic sqrt_last;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic                       cmd;
      logic                       last;
      logic                       view_active;
      logic signed [POS_W-1:0]    pos_x;
      logic signed [POS_W-1:0]    pos_y;
      logic signed [POS_W-1:0]    pos_z;
      logic signed [HEIGHT_W-1:0] view_height;
      logic [ANGLE_W-1:0]         yaw;
      logic [ANGLE_W-1:0]         pitch;
      logic [KIND_W-1:0]          entity_kind;
      logic [MODEL_W-1:0]         model_index;
   } req_item_type;

   // Odd polynomial coefficients of the quarter-wave sine, Q30, after the first
   function automatic logic [31:0] sine_coef(input logic [1:0] idx);
      logic [31:0] c;
      case (idx)
         2'd0:    c = 32'd5026998;
         2'd1:    c = 32'd85569306;
         2'd2:    c = 32'd693598669;
         2'd3:    c = 32'd1686629713;
         default: c = 32'd0;
      endcase
      return c;
   endfunction

endpackage

FILE: hw/rtl/nevc_if.sv
// Valid/ready channel interfaces for view/entity items and hover results.
// Depends on nevc_pkg for field widths.
interface nevc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 cmd;
   logic                                 last;
   logic                                 view_active;
   logic signed [nevc_pkg::POS_W-1:0]    pos_x;
   logic signed [nevc_pkg::POS_W-1:0]    pos_y;
   logic signed [nevc_pkg::POS_W-1:0]    pos_z;
   logic signed [nevc_pkg::HEIGHT_W-1:0] view_height;
   logic [nevc_pkg::ANGLE_W-1:0]         yaw;
   logic [nevc_pkg::ANGLE_W-1:0]         pitch;
   logic [nevc_pkg::KIND_W-1:0]          entity_kind;
   logic [nevc_pkg::MODEL_W-1:0]         model_index;

   modport source (output valid, cmd, last, view_active, pos_x, pos_y, pos_z, view_height,
                   yaw, pitch, entity_kind, model_index, input ready);
   modport sink (input valid, cmd, last, view_active, pos_x, pos_y, pos_z, view_height,
                 yaw, pitch, entity_kind, model_index, output ready);
endinterface

interface nevc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [nevc_pkg::HIT_W-1:0]   hit_kind;
   logic [nevc_pkg::INDEX_W-1:0] item_index;

   modport source (output valid, hit_kind, item_index, input ready);
   modport sink (input valid, hit_kind, item_index, output ready);
endinterface

FILE: hw/rtl/nevc_ctrl.sv
// Sequencer for the view cone finder: steps the datapath through each item.
// Depends on nevc_pkg for command and status types.
module nevc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  nevc_pkg::status_type st,
   output nevc_pkg::cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_SIN  = 7'b0000010,
      ST_DIR  = 7'b0000100,
      ST_SQ   = 7'b0001000,
      ST_SQRT = 7'b0010000,
      ST_DOT  = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

   localparam logic [2:0] SIN_LAST = 3'd6;
   localparam logic [2:0] DIR_LAST = 3'd2;
   localparam logic [2:0] SQ_LAST  = 3'd3;
   localparam logic [2:0] DOT_LAST = 3'd4;
   localparam logic [1:0] ANG_LAST = 2'd3;

   state_type  state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic [1:0] angle_ff, angle_in;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      angle_in  = angle_ff;
      req_ready = 1'b0;
      cmd.op    = nevc_pkg::OP_IDLE;
      cmd.step  = step_ff;
      cmd.angle = angle_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            step_in   = 3'd0;
            angle_in  = 2'd0;
            if (req_valid) begin
               cmd.op = nevc_pkg::OP_LOAD;
               if (st.is_view) state_in = ST_SIN;
               else if (st.needs_work) state_in = ST_SQ;
               else state_in = ST_FIN;
            end
         end
         ST_SIN: begin
            cmd.op = nevc_pkg::OP_SIN;
            if (step_ff == SIN_LAST) begin
               step_in  = 3'd0;
               angle_in = angle_ff + 2'd1;
               if (angle_ff == ANG_LAST) state_in = ST_DIR;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_DIR: begin
            cmd.op = nevc_pkg::OP_DIR;
            if (step_ff == DIR_LAST) begin
               step_in  = 3'd0;
               state_in = ST_FIN;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_SQ: begin
            cmd.op = nevc_pkg::OP_SQ;
            if (step_ff == SQ_LAST) begin
               step_in  = 3'd0;
               state_in = ST_SQRT;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_SQRT: begin
            cmd.op = nevc_pkg::OP_SQRT;
            if (st.sqrt_last) state_in = ST_DOT;
         end
         ST_DOT: begin
            cmd.op = nevc_pkg::OP_DOT;
            if (step_ff == DOT_LAST) begin
               step_in  = 3'd0;
               state_in = ST_FIN;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_FIN: begin
            // for a last item, hold until the result register is free
            if (!st.last) begin
               state_in = ST_IDLE;
            end else if (st.out_free) begin
               cmd.op   = nevc_pkg::OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= 3'd0;
         angle_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         angle_ff <= angle_in;
      end
   end

endmodule

FILE: hw/rtl/nevc_dpath.sv
// Datapath: view and best-hit state, sine polynomial, shared multiplier,
// bit-serial square root and result register. Depends on nevc_pkg.
module nevc_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  nevc_pkg::req_item_type                req,
   input  nevc_pkg::cmd_type                     cmd,
   output nevc_pkg::status_type                  st,
   input  logic                                  csr_wr_en,
   input  logic [nevc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [nevc_pkg::CSR_DATA_W-1:0]       csr_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [nevc_pkg::HIT_W-1:0]            rsp_hit_kind,
   output logic [nevc_pkg::INDEX_W-1:0]          rsp_item_index
);

   localparam int Z_W = nevc_pkg::POS_W + 2;
   localparam logic signed [Z_W-1:0] Z_MAX = Z_W'(8388607);
   localparam logic signed [Z_W-1:0] Z_MIN = -Z_W'(8388608);
   localparam logic [nevc_pkg::PHASE_W-1:0] QUARTER = 24'h400000;
   localparam logic [nevc_pkg::SQ_W-2:0] BIT_START = (nevc_pkg::SQ_W-1)'(1) << (nevc_pkg::SQ_W-2);
   localparam logic [nevc_pkg::ROOT_W-1:0] D_MIN = nevc_pkg::ROOT_W'(1) << nevc_pkg::POS_FRAC_BITS;
   localparam logic [16:0] S_FULL = 17'd32768;

   logic [nevc_pkg::DIST_W-1:0]       max_dist_ff;
   logic signed [nevc_pkg::COS_W-1:0] cos_cone_ff;

   logic signed [nevc_pkg::POS_W-1:0]  eye_x_ff, eye_y_ff, eye_z_ff;
   logic signed [nevc_pkg::DIR_W-1:0]  dir_x_ff, dir_y_ff, dir_z_ff;
   logic                               active_ff, last_ff;
   logic [nevc_pkg::DIST_W-1:0]        best_distance_ff;
   logic [nevc_pkg::HIT_W-1:0]         best_kind_ff;
   logic [nevc_pkg::INDEX_W-1:0]       best_index_ff;
   logic [nevc_pkg::PHASE_W-1:0]       yaw_ph_ff, pitch_ph_ff;
   logic signed [nevc_pkg::DIFF_W-1:0] dx_ff, dy_ff, dz_ff;
   logic [nevc_pkg::KIND_W-1:0]        kind_ff;
   logic [nevc_pkg::MODEL_W-1:0]       model_ff;
   logic [nevc_pkg::T_W-1:0]           t_ff, t2_ff;
   logic                               neg_ff;
   logic signed [nevc_pkg::DIR_W-1:0]  sin_ff [4];
   logic signed [nevc_pkg::PROD_W-1:0] prod_ff;
   logic signed [nevc_pkg::ACC_W-1:0]  acc_ff;
   logic [nevc_pkg::SQ_W-1:0]          rem_ff, root_ff;
   logic [nevc_pkg::SQ_W-2:0]          bit_ff;
   logic                               rsp_valid_ff;
   logic [nevc_pkg::HIT_W-1:0]         rsp_kind_ff;
   logic [nevc_pkg::INDEX_W-1:0]       rsp_index_ff;

   logic signed [Z_W-1:0]              z_sum, z_sat;
   logic [nevc_pkg::PHASE_W-1:0]       ph;
   logic [22:0]                        xq;
   logic [nevc_pkg::T_W-1:0]           t_sel;
   logic [31:0]                        prod_hi, p_new;
   logic [32:0]                        s_sum;
   logic [16:0]                        s_mag;
   logic signed [nevc_pkg::DIR_W-1:0]  s_val;
   logic signed [31:0]                 rs_v;
   logic [31:0]                        rs_mag;
   logic [16:0]                        rs_r;
   logic signed [nevc_pkg::DIR_W-1:0]  rs_val;
   logic signed [nevc_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic signed [2*nevc_pkg::MUL_W-1:0] mul_full;
   logic signed [nevc_pkg::ACC_W-1:0]  acc_sum;
   logic [nevc_pkg::SQ_W:0]            trial;
   logic [nevc_pkg::ROOT_W-1:0]        d;
   logic                               hit_ok;
   logic [nevc_pkg::HIT_W-1:0]         hit_kind;
   logic [nevc_pkg::INDEX_W-1:0]       hit_index;
   logic                               out_free;

   assign z_sum = Z_W'(req.pos_z) + (Z_W'(req.view_height) <<< nevc_pkg::POS_FRAC_BITS);
   assign z_sat = (z_sum > Z_MAX) ? Z_MAX : ((z_sum < Z_MIN) ? Z_MIN : z_sum);

   // phase of the selected sine: yaw or pitch, plus a quarter turn for cosine
   assign ph    = (cmd.angle[1] ? pitch_ph_ff : yaw_ph_ff) + (cmd.angle[0] ? QUARTER : '0);
   assign xq    = ph[22] ? (23'h400000 - {1'b0, ph[21:0]}) : {1'b0, ph[21:0]};
   assign t_sel = {xq, 8'd0};

   assign prod_hi = prod_ff[61:30];
   assign p_new   = nevc_pkg::sine_coef(2'(cmd.step - 3'd2)) - prod_hi;
   assign s_sum   = {1'b0, prod_hi} + 33'd16384;
   assign s_mag   = (s_sum[32:15] > 18'(S_FULL)) ? S_FULL : s_sum[31:15];
   assign s_val   = neg_ff ? -signed'(s_mag) : signed'(s_mag);

   // round half away from zero by 2^15
   assign rs_v   = prod_ff[31:0];
   assign rs_mag = rs_v[31] ? 32'(-rs_v) : 32'(rs_v);
   assign rs_r   = 17'((rs_mag + 32'd16384) >> 15);
   assign rs_val = rs_v[31] ? -signed'(rs_r) : signed'(rs_r);

   assign acc_sum = acc_ff + prod_ff[nevc_pkg::ACC_W-1:0];
   assign trial   = {1'b0, root_ff} + (nevc_pkg::SQ_W+1)'(bit_ff);
   assign d       = root_ff[nevc_pkg::ROOT_W-1:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         nevc_pkg::OP_SIN: begin
            if (cmd.step == 3'd0) begin
               mul_a = nevc_pkg::MUL_W'(t_sel);
               mul_b = nevc_pkg::MUL_W'(t_sel);
            end else if (cmd.step == 3'd1) begin
               mul_a = nevc_pkg::MUL_W'(prod_hi);
               mul_b = nevc_pkg::MUL_W'(nevc_pkg::SINE_C_FIRST);
            end else begin
               mul_a = (cmd.step == 3'd5) ? nevc_pkg::MUL_W'(t_ff) : nevc_pkg::MUL_W'(t2_ff);
               mul_b = nevc_pkg::MUL_W'(p_new);
            end
         end
         nevc_pkg::OP_DIR: begin
            mul_a = nevc_pkg::MUL_W'(sin_ff[3]);
            mul_b = (cmd.step == 3'd0) ? nevc_pkg::MUL_W'(sin_ff[1]) : nevc_pkg::MUL_W'(sin_ff[0]);
         end
         nevc_pkg::OP_SQ: begin
            case (cmd.step)
               3'd0:    begin mul_a = nevc_pkg::MUL_W'(dx_ff); mul_b = nevc_pkg::MUL_W'(dx_ff); end
               3'd1:    begin mul_a = nevc_pkg::MUL_W'(dy_ff); mul_b = nevc_pkg::MUL_W'(dy_ff); end
               3'd2:    begin mul_a = nevc_pkg::MUL_W'(dz_ff); mul_b = nevc_pkg::MUL_W'(dz_ff); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         nevc_pkg::OP_DOT: begin
            case (cmd.step)
               3'd0:    begin mul_a = nevc_pkg::MUL_W'(dx_ff); mul_b = nevc_pkg::MUL_W'(dir_x_ff); end
               3'd1:    begin mul_a = nevc_pkg::MUL_W'(dy_ff); mul_b = nevc_pkg::MUL_W'(dir_y_ff); end
               3'd2:    begin mul_a = nevc_pkg::MUL_W'(dz_ff); mul_b = nevc_pkg::MUL_W'(dir_z_ff); end
               3'd3:    begin
                  mul_a = nevc_pkg::MUL_W'(cos_cone_ff);
                  mul_b = signed'(nevc_pkg::MUL_W'(d));
               end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;

   // final check of an entity: distance limits, cone and strictly nearer; also the hit kind and index
   always_comb begin
      hit_ok = (d >= D_MIN) && (d <= nevc_pkg::ROOT_W'(max_dist_ff))
               && !(nevc_pkg::PROD_W'(acc_ff) < prod_ff)
               && (d < nevc_pkg::ROOT_W'(best_distance_ff));
      if (kind_ff == nevc_pkg::ENT_PLAYER) begin
         hit_kind  = nevc_pkg::HIT_PLAYER;
         hit_index = '0;
      end else if (model_ff >= 8'd1
                   && 9'(model_ff) < 9'(nevc_pkg::ITEM_NAME_COUNT)) begin
         hit_kind  = nevc_pkg::HIT_NAMED;
         hit_index = model_ff[nevc_pkg::INDEX_W-1:0];
      end else begin
         hit_kind  = nevc_pkg::HIT_GENERIC;
         hit_index = '0;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   assign st.is_view    = (req.cmd == nevc_pkg::CMD_VIEW);
   assign st.needs_work = (req.cmd == nevc_pkg::CMD_ENTITY) && active_ff
                          && (req.entity_kind == nevc_pkg::ENT_PICKUP
                              || req.entity_kind == nevc_pkg::ENT_PLAYER);
   assign st.last       = last_ff;
   assign st.sqrt_last  = bit_ff[0];
   assign st.out_free   = out_free;

   // control state: configuration, frame flag, best hit, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff      <= nevc_pkg::MAX_DIST_RESET;
         cos_cone_ff      <= nevc_pkg::COS_CONE_RESET;
         active_ff        <= 1'b0;
         best_distance_ff <= nevc_pkg::MAX_DIST_RESET;
         best_kind_ff     <= nevc_pkg::HIT_NONE;
         best_index_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               nevc_pkg::CSR_MAX_DIST: max_dist_ff <= csr_data;
               nevc_pkg::CSR_COS_CONE: cos_cone_ff <= csr_data[nevc_pkg::COS_W-1:0];
               default: ;
            endcase
         end
         if (rsp_ready) rsp_valid_ff <= 1'b0;
         case (cmd.op)
            nevc_pkg::OP_LOAD: begin
               if (req.cmd == nevc_pkg::CMD_VIEW) begin
                  active_ff        <= req.view_active;
                  best_distance_ff <= max_dist_ff;
                  best_kind_ff     <= nevc_pkg::HIT_NONE;
                  best_index_ff    <= '0;
               end
            end
            nevc_pkg::OP_DOT: begin
               if (cmd.step == 3'd4 && hit_ok) begin
                  best_distance_ff <= nevc_pkg::DIST_W'(d);
                  best_kind_ff     <= hit_kind;
                  best_index_ff    <= hit_index;
               end
            end
            nevc_pkg::OP_EMIT: begin
               rsp_valid_ff     <= 1'b1;
               best_distance_ff <= max_dist_ff;
               best_kind_ff     <= nevc_pkg::HIT_NONE;
               best_index_ff    <= '0;
            end
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_full[nevc_pkg::PROD_W-1:0];
      case (cmd.op)
         nevc_pkg::OP_LOAD: begin
            last_ff <= req.last;
            if (req.cmd == nevc_pkg::CMD_VIEW) begin
               eye_x_ff    <= req.pos_x;
               eye_y_ff    <= req.pos_y;
               eye_z_ff    <= nevc_pkg::POS_W'(z_sat);
               yaw_ph_ff   <= nevc_pkg::PHASE_W'(32'(req.yaw)
                                                 << (nevc_pkg::PHASE_W - nevc_pkg::ANGLE_BITS));
               pitch_ph_ff <= nevc_pkg::PHASE_W'(32'(req.pitch)
                                                 << (nevc_pkg::PHASE_W - nevc_pkg::ANGLE_BITS));
            end else begin
               dx_ff    <= nevc_pkg::DIFF_W'(req.pos_x) - nevc_pkg::DIFF_W'(eye_x_ff);
               dy_ff    <= nevc_pkg::DIFF_W'(req.pos_y) - nevc_pkg::DIFF_W'(eye_y_ff);
               dz_ff    <= nevc_pkg::DIFF_W'(req.pos_z) - nevc_pkg::DIFF_W'(eye_z_ff);
               kind_ff  <= req.entity_kind;
               model_ff <= req.model_index;
            end
         end
         nevc_pkg::OP_SIN: begin
            if (cmd.step == 3'd0) begin
               t_ff   <= t_sel;
               neg_ff <= ph[23];
            end else if (cmd.step == 3'd1) begin
               t2_ff <= prod_hi[nevc_pkg::T_W-1:0];
            end else if (cmd.step == 3'd6) begin
               sin_ff[cmd.angle] <= s_val;
            end
         end
         nevc_pkg::OP_DIR: begin
            if (cmd.step == 3'd1) dir_x_ff <= rs_val;
            if (cmd.step == 3'd2) begin
               dir_y_ff <= rs_val;
               dir_z_ff <= -sin_ff[2];
            end
         end
         nevc_pkg::OP_SQ: begin
            if (cmd.step == 3'd1) acc_ff <= prod_ff[nevc_pkg::ACC_W-1:0];
            if (cmd.step == 3'd2) acc_ff <= acc_sum;
            if (cmd.step == 3'd3) begin
               rem_ff  <= acc_sum[nevc_pkg::SQ_W-1:0];
               root_ff <= '0;
               bit_ff  <= BIT_START;
            end
         end
         nevc_pkg::OP_SQRT: begin
            if ({1'b0, rem_ff} >= trial) begin
               rem_ff  <= rem_ff - trial[nevc_pkg::SQ_W-1:0];
               root_ff <= (root_ff >> 1) + nevc_pkg::SQ_W'(bit_ff);
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         nevc_pkg::OP_DOT: begin
            if (cmd.step == 3'd1) acc_ff <= prod_ff[nevc_pkg::ACC_W-1:0];
            if (cmd.step == 3'd2 || cmd.step == 3'd3) acc_ff <= acc_sum;
         end
         nevc_pkg::OP_EMIT: begin
            rsp_kind_ff  <= best_kind_ff;
            rsp_index_ff <= best_index_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit_kind   = rsp_kind_ff;
   assign rsp_item_index = rsp_index_ff;

endmodule

FILE: hw/rtl/nearest_entity_in_view_cone_top.sv
// Top level of the view cone nearest entity finder: controller plus datapath.
// Depends on nevc_pkg, nevc_if, nevc_ctrl and nevc_dpath.
//
//   channel | dir | transfer moves
//   req_ch  | in  | one view or entity item
//   rsp_ch  | out | one hover result per item marked last
//   csr_*   | in  | one register write, no handshake
//
// A view item runs four sines on the shared multiplier, then the forward vector,
// then a finishing step. A tested entity squares and sums its offsets, runs the
// bit-serial square root, then the cone and distance checks; a skipped entity
// goes straight to finish. One item is in work at a time.
// Reset is synchronous and leaves best_distance at the reset max_dist.
// A stalled result stays in the output register; the next item is accepted
// meanwhile and only a further last item waits for it to drain.
module nearest_entity_in_view_cone_top (
   input  logic                            clock,
   input  logic                            reset,
   nevc_req_if.sink                        req_ch,
   nevc_rsp_if.source                      rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [nevc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [nevc_pkg::CSR_DATA_W-1:0] csr_data
);

   nevc_pkg::req_item_type req;
   nevc_pkg::cmd_type      cmd;
   nevc_pkg::status_type   st;
   logic                   ready;

   assign req.cmd         = req_ch.cmd;
   assign req.last        = req_ch.last;
   assign req.view_active = req_ch.view_active;
   assign req.pos_x       = req_ch.pos_x;
   assign req.pos_y       = req_ch.pos_y;
   assign req.pos_z       = req_ch.pos_z;
   assign req.view_height = req_ch.view_height;
   assign req.yaw         = req_ch.yaw;
   assign req.pitch       = req_ch.pitch;
   assign req.entity_kind = req_ch.entity_kind;
   assign req.model_index = req_ch.model_index;
   assign req_ch.ready    = ready;

   nevc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ready),
      .st        (st),
      .cmd       (cmd)
   );

   nevc_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req            (req),
      .cmd            (cmd),
      .st             (st),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_hit_kind   (rsp_ch.hit_kind),
      .rsp_item_index (rsp_ch.item_index)
   );

endmodule

FILE: tb/nearest_entity_in_view_cone_top_test.sv
// Testbench for nearest_entity_in_view_cone_top: random and directed view/entity frames,
// checked against a cycle-free predictor of the hover result. Depends on nevc_pkg and nevc_if.
`timescale 1ns / 100ps

module nearest_entity_in_view_cone_top_test;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 60;

   typedef struct packed {
      logic [nevc_pkg::HIT_W-1:0]   hit_kind;
      logic [nevc_pkg::INDEX_W-1:0] item_index;
   } hover_type;

   class hover_scoreboard;
      logic [nevc_pkg::DIST_W-1:0]       max_dist;
      logic signed [nevc_pkg::COS_W-1:0] cos_cone;
      longint                            eye_x, eye_y, eye_z;
      longint                            dir_x, dir_y, dir_z;
      bit                                frame_active;
      longint unsigned                   best_distance;
      logic [nevc_pkg::HIT_W-1:0]        best_kind;
      logic [nevc_pkg::INDEX_W-1:0]      best_index;
      hover_type                         pending[$];
      int                                errors;

      function void clear_best();
         best_distance = 64'(max_dist);
         best_kind     = nevc_pkg::HIT_NONE;
         best_index    = '0;
      endfunction

      function void reset_state();
         max_dist = nevc_pkg::MAX_DIST_RESET;
         cos_cone = nevc_pkg::COS_CONE_RESET;
         eye_x = 0; eye_y = 0; eye_z = 0;
         dir_x = 0; dir_y = 0; dir_z = 0;
         frame_active = 0;
         errors = 0;
         clear_best();
      endfunction

      function void set_reg(logic [nevc_pkg::CSR_IDX_W-1:0] idx,
                            logic [nevc_pkg::CSR_DATA_W-1:0] data);
         if (idx == nevc_pkg::CSR_MAX_DIST) max_dist = data[nevc_pkg::DIST_W-1:0];
         else cos_cone = data[nevc_pkg::COS_W-1:0];
      endfunction

      // quarter-wave sine, x is Q22 within one quarter turn
      function longint quarter_wave(longint unsigned x);
         longint unsigned t, t2, p, s;
         t  = x << 8;
         t2 = (t * t) >> 30;
         p  = 64'd172272;
         p  = 64'd5026998 - ((t2 * p) >> 30);
         p  = 64'd85569306 - ((t2 * p) >> 30);
         p  = 64'd693598669 - ((t2 * p) >> 30);
         p  = 64'd1686629713 - ((t2 * p) >> 30);
         s  = (t * p) >> 30;
         s  = (s + 64'd16384) >> 15;
         if (s > 64'd32768) s = 64'd32768;
         return longint'(s);
      endfunction

      function longint sine_of(logic [nevc_pkg::PHASE_W-1:0] phase);
         longint unsigned x;
         longint          s;
         x = 64'(phase[21:0]);
         if (phase[22]) x = (64'd1 << 22) - x;
         s = quarter_wave(x);
         return phase[23] ? -s : s;
      endfunction

      function longint round_q15(longint v);
         longint unsigned mag;
         mag = v < 0 ? -v : v;
         mag = (mag + 64'd16384) >> 15;
         return v < 0 ? -longint'(mag) : longint'(mag);
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function void note_item(nevc_pkg::req_item_type it);
         longint          z, sy, cy, sp, cp, dx, dy, dz, dot;
         longint unsigned d;
         logic [nevc_pkg::PHASE_W-1:0] yp, pp;
         bit              ok;
         hover_type       h;
         if (it.cmd == nevc_pkg::CMD_VIEW) begin
            z = longint'(it.pos_z)
                + longint'(it.view_height) * (longint'(1) << nevc_pkg::POS_FRAC_BITS);
            if (z > 8388607) z = 8388607;
            if (z < -8388608) z = -8388608;
            yp = {it.yaw, 8'd0};
            pp = {it.pitch, 8'd0};
            sy = sine_of(yp);
            cy = sine_of(yp + 24'h400000);
            sp = sine_of(pp);
            cp = sine_of(pp + 24'h400000);
            eye_x = longint'(it.pos_x); eye_y = longint'(it.pos_y); eye_z = z;
            dir_x = round_q15(cp * cy);
            dir_y = round_q15(cp * sy);
            dir_z = -sp;
            frame_active = it.view_active;
            clear_best();
         end else if (frame_active &&
                      (it.entity_kind == nevc_pkg::ENT_PICKUP
                       || it.entity_kind == nevc_pkg::ENT_PLAYER)) begin
            dx = longint'(it.pos_x) - eye_x;
            dy = longint'(it.pos_y) - eye_y;
            dz = longint'(it.pos_z) - eye_z;
            d  = int_sqrt(dx * dx + dy * dy + dz * dz);
            ok = d >= (64'd1 << nevc_pkg::POS_FRAC_BITS) && d <= 64'(max_dist);
            if (ok) begin
               dot = dx * dir_x + dy * dir_y + dz * dir_z;
               if (dot < longint'(cos_cone) * longint'(d)) ok = 0;
            end
            if (ok && d < best_distance) begin
               best_distance = d;
               if (it.entity_kind == nevc_pkg::ENT_PLAYER) begin
                  best_kind  = nevc_pkg::HIT_PLAYER;
                  best_index = '0;
               end else if (it.model_index >= 1
                            && it.model_index < nevc_pkg::ITEM_NAME_COUNT) begin
                  best_kind  = nevc_pkg::HIT_NAMED;
                  best_index = it.model_index[nevc_pkg::INDEX_W-1:0];
               end else begin
                  best_kind  = nevc_pkg::HIT_GENERIC;
                  best_index = '0;
               end
            end
         end
         if (it.last) begin
            h.hit_kind   = best_kind;
            h.item_index = best_index;
            pending.push_back(h);
            clear_best();
         end
      endfunction

      function void check_result(hover_type got);
         hover_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result kind=%0d index=%0d", $time,
                     got.hit_kind, got.item_index);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.hit_kind !== want.hit_kind) begin
            $display("%0t: hit_kind expected %0d actual %0d", $time,
                     want.hit_kind, got.hit_kind);
            errors++;
         end
         if (got.item_index !== want.item_index) begin
            $display("%0t: item_index expected %0d actual %0d", $time,
                     want.item_index, got.item_index);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [nevc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [nevc_pkg::CSR_DATA_W-1:0] csr_data = '0;

   nevc_req_if req_ch ();
   nevc_rsp_if rsp_ch ();

   nearest_entity_in_view_cone_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch.sink),
      .rsp_ch    (rsp_ch.source),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   hover_scoreboard sb = new();
   bit   quiet = 0;
   int   stall_left = 0;
   int   idle_cycles = 0;

   initial begin
      req_ch.valid = 0; req_ch.cmd = 0; req_ch.last = 0; req_ch.view_active = 0;
      req_ch.pos_x = 0; req_ch.pos_y = 0; req_ch.pos_z = 0; req_ch.view_height = 0;
      req_ch.yaw = 0; req_ch.pitch = 0; req_ch.entity_kind = 0; req_ch.model_index = 0;
      rsp_ch.ready = 0;
   end

   // receiver: random stall bursts, none in the quiet part
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left <= int'($urandom_range(1, 14)) - 1;
         rsp_ch.ready <= 0;
      end else begin
         rsp_ch.ready <= 1;
      end
   end

   always @(posedge clock) begin
      hover_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.hit_kind   = rsp_ch.hit_kind;
         got.item_index = rsp_ch.item_index;
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic send_item(nevc_pkg::req_item_type it);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_ch.valid       <= 1;
      req_ch.cmd         <= it.cmd;
      req_ch.last        <= it.last;
      req_ch.view_active <= it.view_active;
      req_ch.pos_x       <= it.pos_x;
      req_ch.pos_y       <= it.pos_y;
      req_ch.pos_z       <= it.pos_z;
      req_ch.view_height <= it.view_height;
      req_ch.yaw         <= it.yaw;
      req_ch.pitch       <= it.pitch;
      req_ch.entity_kind <= it.entity_kind;
      req_ch.model_index <= it.model_index;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_item(it);
   endtask

   // drain results, then let a trailing non-reporting item finish
   task automatic drain();
      req_ch.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one write, then an idle gap with the write enable low before the next write
   task automatic write_reg(logic [nevc_pkg::CSR_IDX_W-1:0] idx,
                            logic [nevc_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.set_reg(idx, data);
      @(posedge clock);
   endtask

   function automatic nevc_pkg::req_item_type noise_item();
      nevc_pkg::req_item_type it;
      logic [159:0]           raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      it = raw[$bits(nevc_pkg::req_item_type)-1:0];
      return it;
   endfunction

   function automatic nevc_pkg::req_item_type view_item(bit active, bit last);
      nevc_pkg::req_item_type it;
      it = noise_item();
      it.cmd = nevc_pkg::CMD_VIEW;
      it.view_active = active;
      it.last = last;
      if ($urandom_range(0, 1)) begin
         it.pos_x = 24'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
         it.pos_y = 24'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
         it.pos_z = 24'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      end
      return it;
   endfunction

   // entity mostly placed along the view direction with some scatter, else near the eye or anywhere
   function automatic nevc_pkg::req_item_type aimed_entity(logic [nevc_pkg::KIND_W-1:0] kind,
                                                           bit last);
      nevc_pkg::req_item_type it;
      longint                 r, reach;
      it = noise_item();
      it.cmd = nevc_pkg::CMD_ENTITY;
      it.entity_kind = kind;
      it.last = last;
      if ($urandom_range(0, 3) != 0) begin
         reach = longint'(sb.max_dist) + longint'(sb.max_dist) / 4 + 200;
         if (reach > (1 << 22)) reach = 1 << 22;
         r = longint'($urandom_range(0, int'(reach)));
         it.pos_x = 24'(sb.eye_x + ((sb.dir_x * r) >>> 15)
                        + longint'($urandom_range(0, 64)) - 32);
         it.pos_y = 24'(sb.eye_y + ((sb.dir_y * r) >>> 15)
                        + longint'($urandom_range(0, 64)) - 32);
         it.pos_z = 24'(sb.eye_z + ((sb.dir_z * r) >>> 15)
                        + longint'($urandom_range(0, 64)) - 32);
      end else if ($urandom_range(0, 1)) begin
         it.pos_x = 24'(sb.eye_x + longint'($urandom_range(0, 8192)) - 4096);
         it.pos_y = 24'(sb.eye_y + longint'($urandom_range(0, 8192)) - 4096);
         it.pos_z = 24'(sb.eye_z + longint'($urandom_range(0, 8192)) - 4096);
      end
      if ($urandom_range(0, 1)) it.model_index = 8'($urandom_range(0, 40));
      return it;
   endfunction

   task automatic random_frames(int count);
      int n, k;
      logic [nevc_pkg::KIND_W-1:0] kind;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 19) == 0) begin
            send_item(noise_item());
            n++;
            continue;
         end
         send_item(view_item($urandom_range(0, 9) != 0, $urandom_range(0, 29) == 0));
         n++;
         k = $urandom_range(1, 8);
         for (int i = 0; i < k; i++) begin
            case ($urandom_range(0, 9))
               0:       kind = 2'd0;
               1:       kind = 2'd3;
               2, 3, 4: kind = nevc_pkg::ENT_PLAYER;
               default: kind = nevc_pkg::ENT_PICKUP;
            endcase
            send_item(aimed_entity(kind, i == k - 1));
            n++;
         end
      end
   endtask

   task automatic directed();
      nevc_pkg::req_item_type it;
      logic [nevc_pkg::MODEL_W-1:0] models[5] = '{8'd0, 8'd1, 8'd36, 8'd37, 8'd255};
      // entity before any view: ignored
      it = aimed_entity(nevc_pkg::ENT_PLAYER, 1);
      it.pos_x = 24'sd100; it.pos_y = 24'sd0; it.pos_z = 24'sd0;
      send_item(it);
      // view at the extremes, saturating eye z both ways, the first marked last
      it = view_item(1, 1);
      it.pos_x = 24'sh7FFFFF; it.pos_y = -24'sh800000; it.pos_z = 24'sh7FFFFF;
      it.view_height = 8'sd127; it.yaw = 16'hFFFF; it.pitch = 16'h0000;
      send_item(it);
      it.pos_z = -24'sh800000; it.view_height = -8'sd128; it.yaw = 16'h4000;
      it.pitch = 16'h8000; it.last = 0;
      send_item(it);
      // level view along +x, then model indexes, kinds and distance edges
      it = view_item(1, 0);
      it.pos_x = 24'sd0; it.pos_y = 24'sd0; it.pos_z = 24'sd0; it.view_height = 8'sd0;
      it.yaw = 16'd0; it.pitch = 16'd0;
      send_item(it);
      foreach (models[i]) begin
         it = aimed_entity(nevc_pkg::ENT_PICKUP, 1);
         it.pos_x = 24'(640 - i); it.pos_y = 24'sd0; it.pos_z = 24'sd0;
         it.model_index = models[i];
         send_item(it);
      end
      it = aimed_entity(2'd0, 0);
      it.pos_x = 24'sd100; it.pos_y = 24'sd0; it.pos_z = 24'sd0;
      send_item(it);
      it.entity_kind = 2'd3; send_item(it);
      it.entity_kind = nevc_pkg::ENT_PLAYER; it.pos_x = 24'sd63; send_item(it); // under one unit
      it.pos_x = 24'sd64; send_item(it);                                      // exactly one unit
      it.pos_x = 24'sd64; it.entity_kind = nevc_pkg::ENT_PICKUP; it.model_index = 8'd5;
      send_item(it);                                                         // tie keeps the first
      it.pos_x = 24'sd65537; it.last = 1; send_item(it);                     // beyond max_dist
      it.pos_x = 24'sd65536; it.pos_y = 24'sd0; send_item(it);               // exactly max_dist
      it.pos_x = 24'sd0; it.pos_y = 24'sd500; send_item(it);                 // outside the cone
      // inactive view drops entities
      it = view_item(0, 0);
      send_item(it);
      it = aimed_entity(nevc_pkg::ENT_PLAYER, 1); send_item(it);
   endtask

   initial begin
      logic [nevc_pkg::CSR_DATA_W-1:0] dists[5] = '{23'd65536, 23'd0, 23'h7FFFFF, 23'd300000,
                                                    23'd4000};
      logic [nevc_pkg::COS_W-1:0]      cones[5] = '{16'sd32113, -16'sd32768, 16'sd32767, 16'sd0,
                                                    16'sd28000};
      sb.reset_state();
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      directed();
      random_frames(100);
      drain();
      for (int ph = 1; ph < 6; ph++) begin
         if (ph < 5) begin
            write_reg(nevc_pkg::CSR_MAX_DIST, dists[ph]);
            write_reg(nevc_pkg::CSR_COS_CONE, {7'd0, cones[ph]});
         end else begin
            write_reg(nevc_pkg::CSR_MAX_DIST, 23'($urandom_range(1000, 200000)));
            write_reg(nevc_pkg::CSR_COS_CONE, 23'($urandom_range(0, 65535)));
            quiet = 1;
         end
         random_frames(120);
         drain();
      end
      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
